// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked at every rising clock edge out of reset.
`define HHS_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// Same-cycle implication.
`define HHS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

// Next-cycle implication.
`define HHS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// File: rtl/core/hhs_pkg.sv
// ----------------------------------------------------------------------------
// hhs_pkg
// Shared types and constants for the heading-hold steering controller.
// ----------------------------------------------------------------------------
package hhs_pkg;

   // operation codes carried on the request tuser
   typedef enum logic [1:0] {
      OP_RUN   = 2'd0,
      OP_REARM = 2'd1,
      OP_LOAD  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // configuration register indexes
   localparam logic [2:0] CSR_STEER_GAIN   = 3'd0;
   localparam logic [2:0] CSR_PULSE_MIN    = 3'd1;
   localparam logic [2:0] CSR_PULSE_CENTER = 3'd2;
   localparam logic [2:0] CSR_PULSE_MAX    = 3'd3;
   localparam logic [2:0] CSR_TURN_THR     = 3'd4;
   localparam logic [2:0] CSR_STOP_THR     = 3'd5;

   // reset values
   localparam logic [7:0]  GAIN_RST       = 8'd1;
   localparam logic [15:0] PULSE_MIN_RST  = 16'd2500;
   localparam logic [15:0] PULSE_CTR_RST  = 16'd2765;
   localparam logic [15:0] PULSE_MAX_RST  = 16'd3200;
   localparam logic [15:0] TURN_THR_RST   = 16'd55;
   localparam logic [15:0] STOP_THR_RST   = 16'd20;
   localparam logic [8:0]  TARGET_RST     = 9'd90;

   localparam logic [9:0]  FULL_DEG       = 10'd360;
   localparam logic [9:0]  QUARTER_DEG    = 10'd90;
   localparam logic signed [12:0] HALF_TENTHS = 13'sd1800;
   localparam logic signed [12:0] FULL_TENTHS = 13'sd3600;
   localparam logic [15:0] DRIVE_BASE     = 16'd2028;
   localparam logic [15:0] DRIVE_NEUTRAL  = 16'd2765;

   // x / 10 == (x * 52429) >> 19 exactly for x < 2^16
   localparam logic [16:0] RECIP10        = 17'd52429;
   // pot * 58 / 10 folded into one constant: 58 * 52429
   localparam logic [21:0] DRIVE_SCALE    = 22'd3040882;
   localparam int          RECIP_SHIFT    = 19;

   // middle stage contents, handed to the steering stage
   typedef struct packed {
      logic              run;
      logic signed [8:0] err_deg;
      logic [15:0]       drive;
      logic              turned;
      logic [8:0]        target;
   } mid_type;

endpackage

// File: rtl/core/hhs_steer.sv
// ----------------------------------------------------------------------------
// hhs_steer
// Proportional steering term: center + gain * error, clamped to min/max; center when not a run.
// ----------------------------------------------------------------------------
module hhs_steer (
   input  logic [7:0]       gain,
   input  logic [15:0]      pulse_min,
   input  logic [15:0]      pulse_center,
   input  logic [15:0]      pulse_max,
   input  hhs_pkg::mid_type mid,
   output logic [15:0]      steer_pulse
);
   import hhs_pkg::*;

   logic signed [17:0] prod;
   logic signed [17:0] sum;

   // 9b signed x 9b signed fits 18b
   assign prod = 18'($signed({1'b0, gain}) * mid.err_deg);
   assign sum  = $signed({2'b00, pulse_center}) + prod;

   always_comb begin
      // min test wins when min is above max
      priority if (!mid.run) begin
         steer_pulse = pulse_center;
      end else if (sum < $signed({2'b00, pulse_min})) begin
         steer_pulse = pulse_min;
      end else if (sum > $signed({2'b00, pulse_max})) begin
         steer_pulse = pulse_max;
      end else begin
         steer_pulse = sum[15:0];
      end
   end

endmodule

// File: rtl/core/heading_hold_steering_speed.sv
// ----------------------------------------------------------------------------
// heading_hold_steering_speed
// Heading-hold steering and drive speed controller, one result per beat.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tuser: operation; tdata: sensors, target
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: pulses, error, turn flag, target
//  csr     | in  | csr_we (no ready)      | csr_index, csr_wdata
//
//  Three register stages: input, mid (state update, error / 10, drive pulse),
//  result (gain multiply and clamp). A req beat passes the input, mid and result
//  registers before rsp_tvalid rises; one beat per cycle while rsp is not stalled.
//  Heading state is updated in order as each beat leaves the input stage.
//  Synchronous reset clears valids and loads heading state and config registers with their reset values.
//  A stalled rsp holds the pipe; empty stages still fill behind it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module heading_hold_steering_speed (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // compass_heading[11:0], range_cm[27:12],
                                    // pot_level[35:28], new_target[44:36], zero
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // steer_pulse[15:0], drive_pulse[31:16],
                                    // heading_error_deg[40:32], turn_taken[41],
                                    // target_heading[50:42], zero
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import hhs_pkg::*;

   // config
   logic [7:0]  gain_ff;
   logic [15:0] pmin_ff, pctr_ff, pmax_ff, turn_thr_ff, stop_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff     <= GAIN_RST;
         pmin_ff     <= PULSE_MIN_RST;
         pctr_ff     <= PULSE_CTR_RST;
         pmax_ff     <= PULSE_MAX_RST;
         turn_thr_ff <= TURN_THR_RST;
         stop_thr_ff <= STOP_THR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STEER_GAIN:   gain_ff     <= csr_wdata[7:0];
            CSR_PULSE_MIN:    pmin_ff     <= csr_wdata;
            CSR_PULSE_CENTER: pctr_ff     <= csr_wdata;
            CSR_PULSE_MAX:    pmax_ff     <= csr_wdata;
            CSR_TURN_THR:     turn_thr_ff <= csr_wdata;
            CSR_STOP_THR:     stop_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline control
   logic in_vld_ff, mid_vld_ff, rsp_vld_ff;
   logic adv_rsp, adv_mid;

   assign adv_rsp    = !rsp_vld_ff || rsp_tready;
   assign adv_mid    = !mid_vld_ff || adv_rsp;
   assign req_tready = !in_vld_ff || adv_mid;

   // input stage
   op_type      op_ff;
   logic [11:0] heading_ff;
   logic [15:0] range_ff;
   logic [7:0]  pot_ff;
   logic [8:0]  newt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff      <= op_type'(req_tuser);
         heading_ff <= req_tdata[11:0];
         range_ff   <= req_tdata[27:12];
         pot_ff     <= req_tdata[35:28];
         newt_ff    <= req_tdata[44:36];
      end
   end

   // heading state and mid-stage logic
   logic [8:0]  target_ff, target_in;
   logic        turned_ff, turned_in;
   logic        is_run, turn_now;
   logic [9:0]  t_plus, t_load, t_back;
   logic [8:0]  t_run;
   logic [11:0] t_tenths;
   logic signed [12:0] e_raw, e_wrap;
   logic [10:0] e_mag;
   logic [27:0] q_prod;
   logic [8:0]  q_deg;
   logic [29:0] d_prod;
   logic [15:0] drive_run;
   mid_type     mid_in, mid_ff;

   assign is_run   = (op_ff == OP_RUN);
   assign turn_now = is_run && !turned_ff && (range_ff < turn_thr_ff);
   assign t_plus   = {1'b0, target_ff} + QUARTER_DEG;
   assign t_run    = !turn_now ? target_ff
                   : (t_plus >= FULL_DEG) ? 9'(t_plus - FULL_DEG) : t_plus[8:0];
   assign t_load   = {1'b0, newt_ff};
   assign t_back   = ({1'b0, target_ff} >= QUARTER_DEG)
                   ? {1'b0, target_ff} - QUARTER_DEG
                   : {1'b0, target_ff} + FULL_DEG - QUARTER_DEG;

   always_comb begin
      target_in = target_ff;
      turned_in = turned_ff;
      unique case (op_ff)
         OP_RUN: begin
            target_in = t_run;
            turned_in = turned_ff || turn_now;
         end
         OP_REARM: begin
            if (turned_ff) begin
               turned_in = 1'b0;
               target_in = t_back[8:0];
            end
         end
         OP_LOAD: begin
            target_in = (t_load >= FULL_DEG) ? 9'(t_load - FULL_DEG) : newt_ff;
         end
         OP_NONE: ;
         default: ;
      endcase
   end

   // error in tenths, wrapped once, then truncated toward zero to degrees
   assign t_tenths = {t_run, 3'b000} + {2'b00, t_run, 1'b0};
   assign e_raw    = $signed({1'b0, t_tenths}) - $signed({1'b0, heading_ff});

   always_comb begin
      priority if (e_raw > HALF_TENTHS) begin
         e_wrap = e_raw - FULL_TENTHS;
      end else if (e_raw < -HALF_TENTHS) begin
         e_wrap = e_raw + FULL_TENTHS;
      end else begin
         e_wrap = e_raw;
      end
   end

   assign e_mag  = e_wrap[12] ? 11'(-e_wrap) : e_wrap[10:0];
   assign q_prod = 28'(e_mag * RECIP10);
   assign q_deg  = q_prod[RECIP_SHIFT +: 9];

   assign d_prod    = 30'(pot_ff * DRIVE_SCALE);
   assign drive_run = DRIVE_BASE + 16'(d_prod[RECIP_SHIFT +: 11]);

   always_comb begin
      mid_in.run     = is_run;
      mid_in.turned  = turned_in;
      mid_in.target  = target_in;
      mid_in.err_deg = '0;
      mid_in.drive   = DRIVE_NEUTRAL;
      if (is_run) begin
         mid_in.err_deg = e_wrap[12] ? $signed(-q_deg) : $signed(q_deg);
         if (!(turned_in && (range_ff < stop_thr_ff))) begin
            mid_in.drive = drive_run;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_vld_ff <= 1'b0;
         target_ff  <= TARGET_RST;
         turned_ff  <= 1'b0;
      end else if (adv_mid) begin
         mid_vld_ff <= in_vld_ff;
         if (in_vld_ff) begin
            target_ff <= target_in;
            turned_ff <= turned_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_mid && in_vld_ff) begin
         mid_ff <= mid_in;
      end
   end

   // result stage
   logic [15:0] steer_in;
   logic [15:0] steer_ff, drive_ff;
   logic [8:0]  err_ff, target_out_ff;
   logic        turned_out_ff;

   hhs_steer u_steer (
      .gain         (gain_ff),
      .pulse_min    (pmin_ff),
      .pulse_center (pctr_ff),
      .pulse_max    (pmax_ff),
      .mid          (mid_ff),
      .steer_pulse  (steer_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv_rsp) begin
         rsp_vld_ff <= mid_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_rsp && mid_vld_ff) begin
         steer_ff      <= steer_in;
         drive_ff      <= mid_ff.drive;
         err_ff        <= mid_ff.err_deg;
         turned_out_ff <= mid_ff.turned;
         target_out_ff <= mid_ff.target;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'b0, target_out_ff, turned_out_ff, err_ff, drive_ff, steer_ff};

   // checks
   `HHS_ASSERT(a_target_range, clock, reset, target_ff < 9'd360)
   `HHS_ASSERT_IMP(a_err_range, clock, reset, mid_vld_ff,
      (mid_ff.err_deg <= 9'sd180) && (mid_ff.err_deg >= -9'sd180))
   `HHS_ASSERT_IMP(a_nonrun_err, clock, reset, mid_vld_ff && !mid_ff.run,
      (mid_ff.err_deg == 9'sd0) && (mid_ff.drive == DRIVE_NEUTRAL))
   `HHS_ASSERT_NXT(a_mid_hold, clock, reset, mid_vld_ff && !adv_rsp,
      mid_vld_ff && $stable(mid_ff) && $stable(target_ff) && $stable(turned_ff))

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the heading-hold steering controller. A directed
// table hits field extremes, every operation and the turn, re-arm, load and
// wrap corner cases; then mission-shaped random traffic (load target,
// approach the obstacle, maybe re-arm) runs under several register settings.
// Every result beat is compared with a typed table value or a cycle-free
// prediction, with bursty requests and a result side that stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;
   import hhs_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 166;
   localparam int TENTHS_FULL  = 3600;
   localparam int TENTHS_HALF  = 1800;
   localparam int DEG_FULL     = 360;
   localparam int DEG_QUARTER  = 90;
   localparam int DRIVE_OFFSET = 2028;
   localparam int DRIVE_SLOPE  = 58;
   localparam int DRIVE_IDLE   = 2765;
   // indexes past the last register; writes there must be ignored
   localparam logic [2:0] CSR_SPARE6 = 3'd6;
   localparam logic [2:0] CSR_SPARE7 = 3'd7;

   typedef struct packed {
      op_type      op;
      logic [11:0] heading;
      logic [15:0] range_cm;
      logic [7:0]  pot;
      logic [8:0]  new_target;
   } cmd_type;

   typedef struct packed {
      logic [15:0]       steer;
      logic [15:0]       drive;
      logic signed [8:0] err_deg;
      logic              turned;
      logic [8:0]        target;
   } pulse_type;

   typedef struct packed {
      cmd_type   cmd;
      logic      typed;
      pulse_type want;
   } step_row_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_RARE_STALL, RX_CHOKED} rx_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   // register mirror and heading state
   logic [7:0]  gain_r     = GAIN_RST;
   logic [15:0] pmin_r     = PULSE_MIN_RST;
   logic [15:0] pctr_r     = PULSE_CTR_RST;
   logic [15:0] pmax_r     = PULSE_MAX_RST;
   logic [15:0] turn_thr_r = TURN_THR_RST;
   logic [15:0] stop_thr_r = STOP_THR_RST;
   logic [8:0]  target_r   = TARGET_RST;
   logic        turned_r   = 1'b0;

   pulse_type    awaited_pulses[$];
   step_row_type plan[$];
   int           sent        = 0;
   int           burst_left  = 0;
   int           error_count = 0;
   int           idle_cycles = 0;
   rx_mode_type  rx_mode     = RX_OPEN;
   int           rx_left     = 0;

   heading_hold_steering_speed u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic cmd_type make_cmd(op_type op, int hdg, int rng, int pot, int newt);
      cmd_type c;
      c.op         = op;
      c.heading    = hdg[11:0];
      c.range_cm   = rng[15:0];
      c.pot        = pot[7:0];
      c.new_target = newt[8:0];
      return c;
   endfunction

   function automatic void add_row(op_type op, int hdg, int rng, int pot, int newt,
                                   bit typed, int st, int dr, int er, int tt, int tg);
      step_row_type r;
      r.cmd          = make_cmd(op, hdg, rng, pot, newt);
      r.typed        = typed;
      r.want.steer   = st[15:0];
      r.want.drive   = dr[15:0];
      r.want.err_deg = er[8:0];
      r.want.turned  = tt[0];
      r.want.target  = tg[8:0];
      plan.push_back(r);
   endfunction

   // advances heading state and returns the result beat for one command
   function automatic pulse_type steer_and_drive(cmd_type c);
      pulse_type p;
      int        t;
      int        err_t;
      int        sum;
      p.steer   = pctr_r;
      p.drive   = DRIVE_IDLE[15:0];
      p.err_deg = '0;
      case (c.op)
         OP_RUN: begin
            if (!turned_r && c.range_cm < turn_thr_r) begin
               t = int'(target_r) + DEG_QUARTER;
               if (t >= DEG_FULL) t -= DEG_FULL;
               target_r = t[8:0];
               turned_r = 1'b1;
            end
            err_t = int'(target_r) * 10 - int'(c.heading);
            if (err_t > TENTHS_HALF) err_t -= TENTHS_FULL;
            else if (err_t < -TENTHS_HALF) err_t += TENTHS_FULL;
            err_t = err_t / 10;
            sum = int'(pctr_r) + int'(gain_r) * err_t;
            // low bound is tested first, so min above max yields min
            if (sum < int'(pmin_r)) p.steer = pmin_r;
            else if (sum > int'(pmax_r)) p.steer = pmax_r;
            else p.steer = sum[15:0];
            if (turned_r && c.range_cm < stop_thr_r) begin
               p.drive = DRIVE_IDLE[15:0];
            end else begin
               t = DRIVE_OFFSET + (int'(c.pot) * DRIVE_SLOPE) / 10;
               p.drive = t[15:0];
            end
            p.err_deg = err_t[8:0];
         end
         OP_REARM: begin
            if (turned_r) begin
               turned_r = 1'b0;
               t = int'(target_r) - DEG_QUARTER;
               if (t < 0) t += DEG_FULL;
               target_r = t[8:0];
            end
         end
         OP_LOAD: begin
            t = int'(c.new_target);
            if (t >= DEG_FULL) t -= DEG_FULL;
            target_r = t[8:0];
         end
         default: begin
         end
      endcase
      p.turned = turned_r;
      p.target = target_r;
      return p;
   endfunction

   // called at a rising edge; returns after the beat is taken and any burst-end gap
   task automatic send_beat(cmd_type c, logic typed, pulse_type want);
      pulse_type p;
      req_tvalid <= 1'b1;
      req_tuser  <= c.op;
      req_tdata  <= {3'b000, c.new_target, c.pot, c.range_cm, c.heading};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      p = steer_and_drive(c);
      awaited_pulses.push_back(typed ? want : p);
      sent++;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 30);
      end else begin
         burst_left--;
      end
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_STEER_GAIN:   gain_r     = val[7:0];
         CSR_PULSE_MIN:    pmin_r     = val;
         CSR_PULSE_CENTER: pctr_r     = val;
         CSR_PULSE_MAX:    pmax_r     = val;
         CSR_TURN_THR:     turn_thr_r = val;
         CSR_STOP_THR:     stop_thr_r = val;
         default: begin
         end
      endcase
   endtask

   // result side stall pattern
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_left <= $urandom_range(32, 256);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         RX_OPEN:       rsp_tready <= 1'b1;
         RX_COIN:       rsp_tready <= 1'($urandom_range(0, 1));
         RX_RARE_STALL: rsp_tready <= ($urandom_range(0, 7) != 0);
         default:       rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      pulse_type got;
      pulse_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got.steer   = rsp_tdata[15:0];
            got.drive   = rsp_tdata[31:16];
            got.err_deg = rsp_tdata[40:32];
            got.turned  = rsp_tdata[41];
            got.target  = rsp_tdata[50:42];
            if (awaited_pulses.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: result beat with nothing pending: steer %0d drive %0d",
                           $realtime, got.steer, got.drive);
            end else begin
               want = awaited_pulses.pop_front();
               if (got.steer !== want.steer || got.drive !== want.drive ||
                   got.err_deg !== want.err_deg || got.turned !== want.turned ||
                   got.target !== want.target) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"%0t: mismatch exp/got steer %0d/%0d drive %0d/%0d ",
                               "err %0d/%0d turned %0d/%0d target %0d/%0d"},
                              $realtime, want.steer, got.steer, want.drive, got.drive,
                              want.err_deg, got.err_deg, want.turned, got.turned,
                              want.target, got.target);
               end
            end
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int base;
      int n;
      int far;
      int rng;
      int tgt;
      int ctr;
      //      op        hdg   range  pot newt  typed steer drive  err  turn tgt
      add_row(OP_RUN,   900,  1000,    0,   0, 1, 2765, 2028,    0, 0,  90);
      add_row(OP_RUN,     0, 65535,  255,   0, 1, 2855, 3507,   90, 0,  90);
      add_row(OP_RUN,  3599, 65535,  128,   0, 1, 2855, 2770,   90, 0,  90);
      // unused code with every field at its top: no state change
      add_row(OP_NONE, 4095, 65535,  255, 511, 1, 2765, 2765,    0, 0,  90);
      add_row(OP_REARM,   0,     0,    0,   0, 1, 2765, 2765,    0, 0,  90);
      // obstacle: turn plus stop in one beat
      add_row(OP_RUN,  1800,     0,   10,   0, 1, 2765, 2765,    0, 1, 180);
      add_row(OP_RUN,  4095,    30,  200,   0, 0,    0,    0,    0, 0,   0);
      add_row(OP_RUN,  1000,    19,   77,   0, 0,    0,    0,    0, 0,   0);
      // second close call does not turn again
      add_row(OP_RUN,  2000,    54,  255,   0, 1, 2745, 3507,  -20, 1, 180);
      add_row(OP_REARM,   0,     0,    0,   0, 1, 2765, 2765,    0, 0,  90);
      add_row(OP_LOAD,    0,     0,    0, 511, 1, 2765, 2765,    0, 0, 151);
      add_row(OP_LOAD,    0,     0,    0, 359, 1, 2765, 2765,    0, 0, 359);
      add_row(OP_RUN,     0,    54,  255,   0, 0,    0,    0,    0, 0,   0);
      add_row(OP_REARM,   0,     0,    0,   0, 1, 2765, 2765,    0, 0, 359);
      add_row(OP_LOAD,    0,     0,    0,   0, 1, 2765, 2765,    0, 0,   0);
      add_row(OP_RUN,     1,    55,    0,   0, 0,    0,    0,    0, 0,   0);
      add_row(OP_RUN,    19, 65535,    0,   0, 0,    0,    0,    0, 0,   0);
      add_row(OP_LOAD,    0,     0,    0, 360, 1, 2765, 2765,    0, 0,   0);
      add_row(OP_RUN,  3590, 65535,    0,   0, 0,    0,    0,    0, 0,   0);
      add_row(OP_RUN,  1801, 65535,    0,   0, 0,    0,    0,    0, 0,   0);
      add_row(OP_RUN,  1800, 65535,    0,   0, 0,    0,    0,    0, 0,   0);
      add_row(OP_RUN,  2000,   100,  100,   0, 0,    0,    0,    0, 0,   0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (plan[i]) send_beat(plan[i].cmd, plan[i].typed, plan[i].want);

      for (int ph = 0; ph < PHASES; ph++) begin
         req_tvalid <= 1'b0;
         while (awaited_pulses.size() != 0) @(posedge clock);
         case (ph)
            1: begin
               // min above max
               write_csr(CSR_STEER_GAIN, 16'd255);
               write_csr(CSR_PULSE_MIN, 16'd3000);
               write_csr(CSR_PULSE_CENTER, 16'd2765);
               write_csr(CSR_PULSE_MAX, 16'd2000);
               write_csr(CSR_TURN_THR, 16'd300);
               write_csr(CSR_STOP_THR, 16'd100);
            end
            2: begin
               write_csr(CSR_STEER_GAIN, 16'd0);
               write_csr(CSR_PULSE_MIN, 16'd0);
               write_csr(CSR_PULSE_CENTER, 16'd0);
               write_csr(CSR_PULSE_MAX, 16'd0);
               write_csr(CSR_TURN_THR, 16'd0);
               write_csr(CSR_STOP_THR, 16'd0);
            end
            3: begin
               // upper gain bits are dropped
               write_csr(CSR_STEER_GAIN, 16'hFFFF);
               write_csr(CSR_PULSE_MIN, 16'd0);
               write_csr(CSR_PULSE_CENTER, 16'hFFFF);
               write_csr(CSR_PULSE_MAX, 16'hFFFF);
               write_csr(CSR_TURN_THR, 16'hFFFF);
               write_csr(CSR_STOP_THR, 16'hFFFF);
            end
            4: begin
               // negative steering sums
               write_csr(CSR_STEER_GAIN, 16'd255);
               write_csr(CSR_PULSE_MIN, 16'd0);
               write_csr(CSR_PULSE_CENTER, 16'd0);
               write_csr(CSR_PULSE_MAX, 16'hFFFF);
               write_csr(CSR_TURN_THR, 16'd1000);
               write_csr(CSR_STOP_THR, 16'd500);
            end
            5, 6: begin
               ctr = $urandom_range(1500, 4000);
               write_csr(CSR_STEER_GAIN, (ph == 6) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(0, 255)));
               write_csr(CSR_PULSE_CENTER, 16'(ctr));
               write_csr(CSR_PULSE_MIN, 16'(ctr - $urandom_range(0, 800)));
               write_csr(CSR_PULSE_MAX, 16'(ctr + $urandom_range(0, 800)));
               write_csr(CSR_TURN_THR, 16'($urandom_range(0, 400)));
               write_csr(CSR_STOP_THR, 16'($urandom_range(0, 450)));
               if (ph == 6) begin
                  write_csr(CSR_SPARE6, 16'($urandom_range(0, 65535)));
                  write_csr(CSR_SPARE7, 16'($urandom_range(0, 65535)));
               end
            end
            7: begin
               write_csr(CSR_STEER_GAIN, 16'($urandom_range(0, 255)));
               write_csr(CSR_PULSE_MIN, 16'($urandom_range(0, 65535)));
               write_csr(CSR_PULSE_CENTER, 16'($urandom_range(0, 65535)));
               write_csr(CSR_PULSE_MAX, 16'($urandom_range(0, 65535)));
               write_csr(CSR_TURN_THR, 16'($urandom_range(0, 2000)));
               write_csr(CSR_STOP_THR, 16'($urandom_range(0, 2000)));
            end
            default: begin
            end
         endcase
         csr_we <= 1'b0;

         base = sent;
         while (sent - base < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
               // mission: set a heading, close in on the obstacle, maybe re-arm
               far = ((turn_thr_r > stop_thr_r) ? turn_thr_r : stop_thr_r)
                     + $urandom_range(1, 200);
               if (far > 65535) far = 65535;
               n = $urandom_range(4, 12);
               tgt = ($urandom_range(0, 9) == 0) ? $urandom_range(360, 511)
                                                 : $urandom_range(0, 359);
               send_beat(make_cmd(OP_LOAD, $urandom_range(0, 4095), $urandom_range(0, 65535),
                                  $urandom_range(0, 255), tgt), 1'b0, '0);
               for (int k = 0; k < n; k++) begin
                  rng = far - (far * k) / (n - 1) + $urandom_range(0, 3);
                  if (rng > 65535) rng = 65535;
                  send_beat(make_cmd(OP_RUN,
                                     ($urandom_range(0, 7) == 0) ? $urandom_range(3600, 4095)
                                                                 : $urandom_range(0, 3599),
                                     rng, $urandom_range(0, 255), $urandom_range(0, 511)),
                            1'b0, '0);
               end
               if ($urandom_range(0, 1))
                  send_beat(make_cmd(OP_REARM, $urandom_range(0, 4095),
                                     $urandom_range(0, 65535), $urandom_range(0, 255),
                                     $urandom_range(0, 511)), 1'b0, '0);
            end else begin
               send_beat(make_cmd(op_type'($urandom_range(0, 3)), $urandom_range(0, 4095),
                                  $urandom_range(0, 65535), $urandom_range(0, 255),
                                  $urandom_range(0, 511)), 1'b0, '0);
            end
         end
      end

      req_tvalid <= 1'b0;
      while (awaited_pulses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && awaited_pulses.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/hhs_pkg.sv
rtl/core/hhs_steer.sv
rtl/core/heading_hold_steering_speed.sv
dv/testbench.sv
